[rtl/octave_grid_noise_height_core_macros.svh]
// Assertion macros for the octave grid noise height core.
`ifndef OCTAVE_GRID_NOISE_HEIGHT_CORE_MACROS_SVH
`define OCTAVE_GRID_NOISE_HEIGHT_CORE_MACROS_SVH
// Assert that an antecedent implies a consequent on the next clock.
`define OGN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that a condition always holds.
`define OGN_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`endif

[rtl/ognh_pkg.sv]
// Package with the types and constants of the octave grid noise height core.
package ognh_pkg;
    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_SQ, S_RD, S_RDW, S_MUL, S_ACC, S_ROUND, S_OUT
    } t_state;
    localparam int GRID_SIZE = 256;
    localparam int OCT_LIMIT = 8;
    localparam int FRAC_W = 16;
    localparam int HEIGHT_W = 16;
    localparam int PIX_W = 20;
    localparam int CNT_W = 4;
endpackage

[rtl/octave_grid_noise_height_core.sv]
// Top level of the octave grid noise height core.
// Write words (op 0) store one Q1.15 boundary height at (row, col) in a
// GRID_SIZE x GRID_SIZE store; they go from the accepting idle state to the
// output state, which returns to idle without waiting for ready. Pixel
// words (op 1) sum octave_count octaves of smoothstep value noise and
// deliver one Q5.15 saturated height. Each octave runs one setup step that
// derives the cell corners and the fractions by shifts (cells are powers of
// two), seven passes through one shared 18x18 multiplier for x^2, x^3, y^2,
// y^3 and the cross terms, four reads of the single-port height store plus
// a wait state for the registered read data, three blend multiplies and one
// accumulate. A pixel goes through the accepting idle state, the octaves, a
// rounding state and an output state that holds the result until ready.
// The core accepts nothing while a word is in progress. The store port and
// the shared multiplier set the rate.
// Entries must be written before a pixel reads them; the store has no reset
// and no clearing pass.
`include "octave_grid_noise_height_core_macros.svh"
module octave_grid_noise_height_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ognh_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [7:0]                    i_row,
    input  logic [7:0]                    i_col,
    input  logic signed [15:0]            i_height_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ognh_pkg::PIX_W-1:0] o_pixel_height
);
    import ognh_pkg::*;

    localparam int AW = $clog2(GRID_SIZE);
    localparam int OW = $clog2(OCT_LIMIT + 1);
    localparam int ACC_W = 16 + 20 + OCT_LIMIT + 4;

    // Height store, one port, registered read.
    logic signed [HEIGHT_W-1:0] r_mem [GRID_SIZE*GRID_SIZE];
    logic signed [HEIGHT_W-1:0] r_rdata;
    logic                       mem_we;
    logic [2*AW-1:0]            mem_addr;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_oct_cfg;
    logic [AW-1:0]    r_row, r_col;
    logic [OW-1:0]    r_oct, r_noct;
    logic [2:0]       r_sub;

    // Cell size is a power of two, so the fraction is a plain shift.
    logic [AW:0]      cell_sz;
    logic [FRAC_W-1:0] r_fx, r_fy;
    logic [AW-1:0]    r_kx, r_ky;
    logic signed [17:0] r_x2, r_y2, r_sx, r_sy, r_inner;
    logic signed [HEIGHT_W-1:0] r_h00, r_h01, r_h10, r_h11;
    logic signed [ACC_W-1:0] r_v, r_acc;
    logic signed [PIX_W-1:0] r_out;

    // Shared multiplier operands.
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [AW-1:0] ix, iy, ix1, iy1, cm1;
    assign cell_sz = (AW+1)'(GRID_SIZE) >> r_oct;
    assign cm1  = AW'(cell_sz - 1'b1);
    // k*(c-1) with k < 2^i: k shifted left by log2 of c, minus k, gives k*c - k.
    assign ix   = AW'(({1'b0, r_kx} << (AW - r_oct)) - r_kx);
    assign iy   = AW'(({1'b0, r_ky} << (AW - r_oct)) - r_ky);
    assign ix1  = ix + cm1;
    assign iy1  = iy + cm1;

    logic signed [17:0] dx, dy, aa;
    assign dx = 18'(r_h10) - 18'(r_h00);
    assign dy = 18'(r_h01) - 18'(r_h00);
    assign aa = dx - 18'(r_h11) + 18'(r_h01);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_sub)
            3'd0: begin mul_a = 18'(r_fx); mul_b = 18'(r_fx); end
            3'd1: begin mul_a = r_x2; mul_b = 18'(r_fx); end
            3'd2: begin mul_a = 18'(r_fy); mul_b = 18'(r_fy); end
            3'd3: begin mul_a = r_y2; mul_b = 18'(r_fy); end
            3'd4: begin mul_a = 18'(r_fx); mul_b = 18'(r_fy); end
            3'd5: begin mul_a = r_sx; mul_b = 18'(r_fy); end
            3'd6: begin mul_a = r_sy; mul_b = 18'(r_fx); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (r_state == S_MUL) begin
            case (r_sub)
                3'd0: begin mul_a = r_sx; mul_b = dx; end
                3'd1: begin mul_a = r_sy; mul_b = dy; end
                3'd2: begin mul_a = aa; mul_b = r_inner; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = i_op ? S_SETUP : S_OUT;
            S_SETUP: n_state = S_SQ;
            S_SQ:    if (r_sub == 3'd6) n_state = S_RD;
            S_RD:    if (r_sub == 3'd3) n_state = S_RDW;
            S_RDW:   n_state = S_MUL;
            S_MUL:   if (r_sub == 3'd2) n_state = S_ACC;
            S_ACC:   n_state = (r_oct + 1'b1 == r_noct) ? S_ROUND : S_SETUP;
            S_ROUND: n_state = S_OUT;
            S_OUT:   if (r_noct == '0 || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT) && (r_noct != '0);
        o_pixel_height = r_out;
        mem_we = (r_state == S_IDLE) && i_valid && !i_op;
        mem_addr = {i_row[AW-1:0], i_col[AW-1:0]};
        if (r_state == S_RD) begin
            case (r_sub[1:0])
                2'd0: mem_addr = {ix, iy};
                2'd1: mem_addr = {ix, iy1};
                2'd2: mem_addr = {ix1, iy};
                default: mem_addr = {ix1, iy1};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= i_height_value;
        r_rdata <= r_mem[mem_addr];
    end

    logic signed [ACC_W-1:0] rsum;
    assign rsum = r_acc + (ACC_W'(1) <<< (15 + OCT_LIMIT - 1));
    logic signed [ACC_W-1:0] rq;
    assign rq = rsum >>> (16 + OCT_LIMIT - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_oct_cfg <= CNT_W'(8);
            r_noct    <= '0;
            r_oct     <= '0;
            r_sub     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_oct_cfg <= i_cfg_wdata;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_row <= i_row[AW-1:0];
                    r_col <= i_col[AW-1:0];
                    r_oct <= '0;
                    r_acc <= '0;
                    // Clamp the octave count; zero count marks a write word.
                    if (!i_op) r_noct <= '0;
                    else if (r_oct_cfg == '0) r_noct <= OW'(1);
                    else if (r_oct_cfg > CNT_W'(OCT_LIMIT)) r_noct <= OW'(OCT_LIMIT);
                    else r_noct <= OW'(r_oct_cfg);
                end
                S_SETUP: begin
                    r_kx  <= AW'(r_row >> (AW - r_oct));
                    r_ky  <= AW'(r_col >> (AW - r_oct));
                    // (rem << 16) / cell, with cell = 2^(AW - octave).
                    r_fx  <= FRAC_W'({r_row & cm1, FRAC_W'(0)} >> (AW - r_oct));
                    r_fy  <= FRAC_W'({r_col & cm1, FRAC_W'(0)} >> (AW - r_oct));
                    r_sub <= '0;
                end
                S_SQ: begin
                    r_sub <= (r_sub == 3'd6) ? 3'd0 : r_sub + 1'b1;
                    case (r_sub)
                        3'd0: r_x2 <= 18'(mul_p >>> 16);
                        3'd1: r_sx <= 18'(3 * r_x2 - 2 * (mul_p >>> 16));
                        3'd2: r_y2 <= 18'(mul_p >>> 16);
                        3'd3: r_sy <= 18'(3 * r_y2 - 2 * (mul_p >>> 16));
                        3'd4: r_inner <= 18'(mul_p >>> 16);
                        3'd5: r_inner <= r_inner - 18'(mul_p >>> 16);
                        default: r_inner <= r_inner - 18'(mul_p >>> 16);
                    endcase
                end
                S_RD: begin
                    r_sub <= r_sub + 1'b1;
                    case (r_sub[1:0])
                        2'd1: r_h00 <= r_rdata;
                        2'd2: r_h01 <= r_rdata;
                        2'd3: r_h10 <= r_rdata;
                        default: ;
                    endcase
                end
                S_RDW: begin
                    r_h11 <= r_rdata;
                    r_sub <= '0;
                    r_v   <= ACC_W'(r_h00) <<< 16;
                end
                S_MUL: begin
                    r_sub <= r_sub + 1'b1;
                    r_v   <= r_v + ACC_W'(mul_p);
                end
                S_ACC: begin
                    r_acc <= r_acc + (r_v <<< (OCT_LIMIT - 1 - r_oct));
                    r_oct <= r_oct + 1'b1;
                end
                S_ROUND: begin
                    if (rq > ACC_W'(524287)) r_out <= PIX_W'(524287);
                    else if (rq < -ACC_W'(524288)) r_out <= PIX_W'(-524288);
                    else r_out <= PIX_W'(rq);
                end
                default: ;
            endcase
        end
    end

    `OGN_ASSERT_ALWAYS(a_ready_idle, i_clk, i_rst_n, !(o_ready && o_valid),
        "ready while result held")
    `OGN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_pixel_height), "result dropped")
    `OGN_ASSERT_ALWAYS(a_oct_range, i_clk, i_rst_n, r_oct <= OW'(OCT_LIMIT), "octave index out of range")
endmodule

[tb/sv/octave_grid_noise_height_core_tb.sv]
// Testbench for the octave grid noise height core: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

class height_scoreboard;
    logic signed [15:0] height_mem [0:65535];
    bit                 written [0:65535];
    logic [3:0]         octaves;
    logic signed [19:0] pending [$];
    int                 errors;
    int                 n_pixels;
    int                 n_writes;

    function new();
        octaves  = 4'd8;
        errors   = 0;
        n_pixels = 0;
        n_writes = 0;
        foreach (written[k]) written[k] = 1'b0;
    endfunction

    static function longint smoothstep(longint f);
        longint f2, f3;
        f2 = (f * f) >>> 16;
        f3 = (f2 * f) >>> 16;
        return 3 * f2 - 2 * f3;
    endfunction

    function int active_octaves();
        if (octaves < 1) return 1;
        if (octaves > 8) return 8;
        return int'(octaves);
    endfunction

    function longint fetch(int r, int c);
        return longint'(height_mem[(r % 256) * 256 + (c % 256)]);
    endfunction

    function logic signed [19:0] pixel_sum(int row, int col);
        longint acc, res, fx, fy, sx, sy, h00, h01, h10, h11, d_x, d_y, a, inner, v;
        int cell_sz, ix, iy, ix1, iy1;
        acc = 0;
        for (int i = 0; i < active_octaves(); i++) begin
            cell_sz = 256 >> i;
            ix  = (row / cell_sz) * (cell_sz - 1);
            iy  = (col / cell_sz) * (cell_sz - 1);
            ix1 = ix + cell_sz - 1;
            iy1 = iy + cell_sz - 1;
            fx = (longint'(row % cell_sz) << 16) / cell_sz;
            fy = (longint'(col % cell_sz) << 16) / cell_sz;
            sx = smoothstep(fx);
            sy = smoothstep(fy);
            h00 = fetch(ix, iy);
            h01 = fetch(ix, iy1);
            h10 = fetch(ix1, iy);
            h11 = fetch(ix1, iy1);
            d_x = h10 - h00;
            d_y = h01 - h00;
            a   = d_x - h11 + h01;
            inner = ((fx * fy) >>> 16) - ((sx * fy) >>> 16) - ((sy * fx) >>> 16);
            v = h00 * 65536 + sx * d_x + sy * d_y + a * inner;
            acc += v <<< (7 - i);
        end
        // Round half up, then clamp to the Q5.15 range.
        res = (acc + (longint'(1) << 22)) >>> 23;
        if (res > 524287) res = 524287;
        if (res < -524288) res = -524288;
        return res[19:0];
    endfunction

    function void note_word(bit op, logic [7:0] row, logic [7:0] col,
                            logic signed [15:0] hv);
        if (op == 1'b0) begin
            height_mem[row * 256 + col] = hv;
            written[row * 256 + col] = 1'b1;
            n_writes++;
        end else begin
            pending.push_back(pixel_sum(int'(row), int'(col)));
            n_pixels++;
        end
    endfunction

    function void check_result(logic signed [19:0] got);
        logic signed [19:0] want;
        if (pending.size() == 0) begin
            $error("pixel_height: unexpected result %0d", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            $error("pixel_height: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module octave_grid_noise_height_core_tb;
    import ognh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_WORDS    = 100;
    localparam int WIN_BASE       = 120;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CNT_W-1:0]         i_cfg_wdata;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_op;
    logic [7:0]               i_row;
    logic [7:0]               i_col;
    logic signed [15:0]       i_height_value;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [PIX_W-1:0]  o_pixel_height;

    height_scoreboard sb;
    int  word_count;
    int  result_count;
    int  idle_cycles;
    bit  quiet_mode;    // no random gaps on either side
    bit  hold_done;

    octave_grid_noise_height_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_height_value (i_height_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_height (o_pixel_height)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check every accepted word at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_pixel_height);
            result_count <= result_count + 1;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the core stalls holding a result.
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && result_count >= 60) begin
                hold_done = 1'b1;
                i_ready = 1'b0;
                repeat (900) @(negedge i_clk);
            end
            i_ready = quiet_mode ? 1'b1 : ($urandom_range(0, 99) >= 6);
        end
    end

    // Present one word and hold it until the core takes it.
    task automatic send_word(bit op, logic [7:0] row, logic [7:0] col,
                             logic signed [15:0] hv);
        if (!quiet_mode && $urandom_range(0, 99) < 6) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_op           = op;
        i_row          = row;
        i_col          = col;
        i_height_value = hv;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(op, row, col, hv);
        word_count++;
        @(negedge i_clk);
    endtask

    // Fill any corner this pixel will read that has never been written, then send the pixel.
    task automatic send_pixel(logic [7:0] row, logic [7:0] col);
        int cell_sz, rr [2], cc [2], idx;
        for (int i = 0; i < sb.active_octaves(); i++) begin
            cell_sz = 256 >> i;
            rr[0] = ((row / cell_sz) * (cell_sz - 1)) % 256;
            rr[1] = ((row / cell_sz) * (cell_sz - 1) + cell_sz - 1) % 256;
            cc[0] = ((col / cell_sz) * (cell_sz - 1)) % 256;
            cc[1] = ((col / cell_sz) * (cell_sz - 1) + cell_sz - 1) % 256;
            for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++) begin
                    idx = rr[a] * 256 + cc[b];
                    if (!sb.written[idx])
                        send_word(1'b0, 8'(rr[a]), 8'(cc[b]), 16'($urandom()));
                end
        end
        send_word(1'b1, row, col, 16'($urandom()));
    endtask

    // Drain, let trailing writes settle, then load a new octave count.
    task automatic set_octaves(logic [3:0] n);
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = n;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.octaves = n;
    endtask

    initial begin
        logic [3:0] settings [8];
        settings       = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7, 4'd8};
        sb             = new();
        word_count     = 0;
        result_count   = 0;
        idle_cycles    = 0;
        quiet_mode     = 1'b0;
        hold_done      = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_op           = 1'b0;
        i_row          = '0;
        i_col          = '0;
        i_height_value = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extreme heights on the outer corners, pixels at the edges
        // of the grid and of the cells, at the reset octave count.
        send_word(1'b0, 8'd0,   8'd0,   16'sh7FFF);
        send_word(1'b0, 8'd255, 8'd255, -16'sh8000);
        send_word(1'b0, 8'd0,   8'd255, -16'sh8000);
        send_word(1'b0, 8'd255, 8'd0,   16'sh7FFF);
        send_pixel(8'd0,   8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd128, 8'd127);
        send_pixel(8'd1,   8'd254);
        // Overwrite an entry, then read it back through a pixel.
        send_word(1'b0, 8'd0, 8'd0, 16'sh0000);
        send_pixel(8'd0, 8'd0);
        // Out-of-range counts act as the nearest legal one.
        set_octaves(4'd0);
        send_pixel(8'd200, 8'd55);
        set_octaves(4'd15);
        send_pixel(8'd200, 8'd55);
        set_octaves(4'd8);

        // Random phases, each with its own octave count. Keep most pixels in
        // a window across the grid center so their corners get reused.
        foreach (settings[p]) begin
            set_octaves(settings[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                quiet_mode = (p == 3);
                if ($urandom_range(0, 99) < 45) begin
                    if ($urandom_range(0, 99) < 5)
                        send_pixel(8'($urandom()), 8'($urandom()));
                    else
                        send_pixel(8'(WIN_BASE + $urandom_range(0, 15)),
                                   8'(WIN_BASE + $urandom_range(0, 15)));
                end else
                    send_word(1'b0, 8'($urandom()), 8'($urandom()), 16'($urandom()));
            end
            // Sender waits for every result before the next phase.
            quiet_mode = 1'b0;
        end

        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d height writes and %0d pixels over octave counts 0..15,",
                 sb.n_writes, sb.n_pixels);
        $display("with random gaps, a long receiver hold-off and full-rate stretches.");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
